// ----- rtl/tilt_yaw_gesture_detector_unit_macros.svh -----
// Assertion macros shared by the tilt and yaw gesture detector RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef TILT_YAW_GESTURE_DETECTOR_UNIT_MACROS_SVH
`define TILT_YAW_GESTURE_DETECTOR_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define TYGD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tygd assertion failed");
// Next-cycle implication, disabled during reset.
`define TYGD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tygd assertion failed");
`else
`define TYGD_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define TYGD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/tygd_pkg.sv -----
// Types and constants of the tilt and yaw gesture detector.
// Used by tygd_eval and tilt_yaw_gesture_detector_unit; depends on nothing.
package tygd_pkg;

   // Angles are degrees times 128.
   localparam logic signed [17:0] FULL_TURN  = 18'sd46080;
   localparam logic signed [17:0] HALF_TURN  = 18'sd23040;
   localparam logic [15:0]        YAW_SEC_90  = 16'd11520;
   localparam logic [15:0]        YAW_SEC_180 = 16'd23040;
   localparam logic [15:0]        YAW_SEC_270 = 16'd34560;

   // Configuration register indexes.
   localparam logic [2:0] CSR_LEVEL_BAND       = 3'd0;
   localparam logic [2:0] CSR_FLIP_BAND        = 3'd1;
   localparam logic [2:0] CSR_ROLL_LOW_LIMIT   = 3'd2;
   localparam logic [2:0] CSR_ROLL_HIGH_LIMIT  = 3'd3;
   localparam logic [2:0] CSR_PITCH_LOW_LIMIT  = 3'd4;
   localparam logic [2:0] CSR_PITCH_HIGH_LIMIT = 3'd5;

   // Configuration reset values.
   localparam logic [14:0] LEVEL_BAND_RST       = 15'd3840;
   localparam logic [14:0] FLIP_BAND_RST        = 15'd3840;
   localparam logic [14:0] ROLL_LOW_LIMIT_RST   = 15'd3840;
   localparam logic [15:0] ROLL_HIGH_LIMIT_RST  = 16'd42240;
   localparam logic [14:0] PITCH_LOW_LIMIT_RST  = 15'd5760;
   localparam logic [15:0] PITCH_HIGH_LIMIT_RST = 16'd40320;

   // Gesture codes.
   localparam logic [3:0] GC_NONE      = 4'd0;
   localparam logic [3:0] GC_LEVEL     = 4'd1;
   localparam logic [3:0] GC_FLIP      = 4'd2;
   localparam logic [3:0] GC_ROLL_LOW  = 4'd3;
   localparam logic [3:0] GC_ROLL_HIGH = 4'd4;
   localparam logic [3:0] GC_FORWARD   = 4'd5;
   localparam logic [3:0] GC_BACKWARD  = 4'd6;
   localparam logic [3:0] GC_YAW90     = 4'd7;
   localparam logic [3:0] GC_YAW180    = 4'd8;
   localparam logic [3:0] GC_YAW270    = 4'd9;

   // Latch bit k holds gesture code k+1.
   localparam int          NUM_LATCHES = 9;
   localparam int          LAT_LEVEL   = 0;
   localparam int          LAT_FLIP    = 1;
   localparam int          LAT_TILT_LO = 2;
   localparam int          LAT_TILT_HI = 5;
   localparam logic [8:0]  TILT_MASK   = 9'h03C;

   typedef struct packed {
      logic [15:0]        roll_angle;
      logic [15:0]        pitch_angle;
      logic signed [15:0] yaw_change;
   } tygd_req_type;

   typedef struct packed {
      logic        report_valid;
      logic [3:0]  gesture_code;
      logic [15:0] yaw_angle;
   } tygd_rsp_type;

   typedef struct packed {
      logic [14:0] level_band;
      logic [14:0] flip_band;
      logic [14:0] roll_low_limit;
      logic [15:0] roll_high_limit;
      logic [14:0] pitch_low_limit;
      logic [15:0] pitch_high_limit;
   } tygd_cfg_type;

   typedef struct packed {
      logic [NUM_LATCHES-1:0] latches;
      logic [15:0]            yaw;
   } tygd_state_type;

endpackage

// ----- rtl/tygd_eval.sv -----
// Single-pass evaluation of one sample: yaw update and wrap, window tests
// and the one-shot gesture latches. Depends on tygd_pkg.
module tygd_eval
   import tygd_pkg::*;
(
   input  tygd_req_type   req,
   input  tygd_cfg_type   cfg,
   input  tygd_state_type cur,
   output tygd_state_type nxt,
   output tygd_rsp_type   rsp
);

   logic signed [17:0] roll_s;
   logic signed [17:0] pitch_s;
   logic signed [17:0] lb_s;
   logic signed [17:0] fb_s;
   logic signed [17:0] yaw_sum;
   logic signed [17:0] yaw_wrap;
   logic [15:0]        yaw_new;
   logic [NUM_LATCHES-1:0] hit;
   logic [NUM_LATCHES-1:0] lat;
   logic [3:0]             fired;

   assign roll_s  = signed'({2'b00, req.roll_angle});
   assign pitch_s = signed'({2'b00, req.pitch_angle});
   assign lb_s    = signed'({3'b000, cfg.level_band});
   assign fb_s    = signed'({3'b000, cfg.flip_band});

   // The sum stays within one turn of range, so a single correction wraps it.
   assign yaw_sum = signed'({2'b00, cur.yaw}) + {{2{req.yaw_change[15]}}, req.yaw_change};

   always_comb begin
      if (yaw_sum > FULL_TURN) begin
         yaw_wrap = yaw_sum - FULL_TURN;
      end else if (yaw_sum < 18'sd0) begin
         yaw_wrap = yaw_sum + FULL_TURN;
      end else begin
         yaw_wrap = yaw_sum;
      end
   end

   assign yaw_new = yaw_wrap[15:0];

   assign hit[0] = (roll_s <= lb_s || roll_s >= FULL_TURN - lb_s) &&
                   (pitch_s >= HALF_TURN - lb_s && pitch_s <= HALF_TURN + lb_s);
   assign hit[1] = (roll_s >= HALF_TURN - fb_s && roll_s <= HALF_TURN + fb_s) &&
                   (pitch_s <= fb_s || pitch_s >= FULL_TURN - fb_s);
   assign hit[2] = roll_s >= signed'({3'b000, cfg.roll_low_limit}) && roll_s < HALF_TURN;
   assign hit[3] = roll_s <= signed'({2'b00, cfg.roll_high_limit}) && roll_s > HALF_TURN;
   assign hit[4] = pitch_s >= signed'({3'b000, cfg.pitch_low_limit}) && pitch_s < HALF_TURN;
   assign hit[5] = pitch_s <= signed'({2'b00, cfg.pitch_high_limit}) && pitch_s > HALF_TURN;
   assign hit[6] = yaw_new >= YAW_SEC_90 && yaw_new < YAW_SEC_180;
   assign hit[7] = yaw_new >= YAW_SEC_180 && yaw_new < YAW_SEC_270;
   assign hit[8] = yaw_new >= YAW_SEC_270;

   // Latches are visited in code order; the last one newly set is reported.
   always_comb begin
      lat   = cur.latches;
      fired = GC_NONE;
      if (hit[LAT_LEVEL]) begin
         if (!lat[LAT_LEVEL]) begin
            lat[LAT_LEVEL] = 1'b1;
            lat[LAT_FLIP]  = 1'b0;
            lat            = lat & ~TILT_MASK;
            fired          = GC_LEVEL;
         end
      end else begin
         lat[LAT_LEVEL] = 1'b0;
      end
      if (hit[LAT_FLIP]) begin
         if (!lat[LAT_FLIP]) begin
            lat[LAT_FLIP]  = 1'b1;
            lat[LAT_LEVEL] = 1'b0;
            lat            = lat & ~TILT_MASK;
            fired          = GC_FLIP;
         end
      end else begin
         lat[LAT_FLIP] = 1'b0;
      end
      // Tilt latches are held while the hand is latched level or upside down.
      for (int i = LAT_TILT_LO; i < NUM_LATCHES; i++) begin
         if (i > LAT_TILT_HI || !(lat[LAT_LEVEL] || lat[LAT_FLIP])) begin
            if (hit[i]) begin
               if (!lat[i]) begin
                  lat[i] = 1'b1;
                  fired  = 4'(i + 1);
               end
            end else begin
               lat[i] = 1'b0;
            end
         end
      end
   end

   assign nxt.latches      = lat;
   assign nxt.yaw          = yaw_new;
   assign rsp.report_valid = (fired != GC_NONE);
   assign rsp.gesture_code = fired;
   assign rsp.yaw_angle    = yaw_new;

endmodule

// ----- rtl/tilt_yaw_gesture_detector_unit.sv -----
// Top level of the tilt and yaw gesture detector: configuration registers,
// sample state and the result register. Depends on tygd_pkg and tygd_eval.
//
//   channel  ports                        direction  handshake
//   req      req_valid/req_ready/req_data  in         valid/ready, tygd_req_type
//   rsp      rsp_valid/rsp_ready/rsp_data  out        valid/ready, tygd_rsp_type
//   csr      csr_we/csr_index/csr_wdata    in         write enable, no wait
//
// One word per cycle: each sample is evaluated in one pass between the input
// port and the result register, so its result appears in the cycle after accept.
// A new word is taken while the previous result is being taken or is empty.
// When rsp_ready is low and a result is held, req_ready drops.
// Synchronous reset clears the yaw, the latches and the result valid, and
// loads the configuration defaults.
`include "tilt_yaw_gesture_detector_unit_macros.svh"
module tilt_yaw_gesture_detector_unit
   import tygd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  tygd_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output tygd_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   tygd_cfg_type   cfg_ff, cfg_in;
   tygd_state_type state_ff, state_in, state_eval;
   tygd_rsp_type   rsp_data_ff, rsp_eval;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   tygd_eval u_eval (
      .req (req_data),
      .cfg (cfg_ff),
      .cur (state_ff),
      .nxt (state_eval),
      .rsp (rsp_eval)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_BAND:       cfg_in.level_band       = csr_wdata[14:0];
            CSR_FLIP_BAND:        cfg_in.flip_band        = csr_wdata[14:0];
            CSR_ROLL_LOW_LIMIT:   cfg_in.roll_low_limit   = csr_wdata[14:0];
            CSR_ROLL_HIGH_LIMIT:  cfg_in.roll_high_limit  = csr_wdata;
            CSR_PITCH_LOW_LIMIT:  cfg_in.pitch_low_limit  = csr_wdata[14:0];
            CSR_PITCH_HIGH_LIMIT: cfg_in.pitch_high_limit = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   assign state_in     = req_fire ? state_eval : state_ff;
   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.level_band       <= LEVEL_BAND_RST;
         cfg_ff.flip_band        <= FLIP_BAND_RST;
         cfg_ff.roll_low_limit   <= ROLL_LOW_LIMIT_RST;
         cfg_ff.roll_high_limit  <= ROLL_HIGH_LIMIT_RST;
         cfg_ff.pitch_low_limit  <= PITCH_LOW_LIMIT_RST;
         cfg_ff.pitch_high_limit <= PITCH_HIGH_LIMIT_RST;
         state_ff                <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_eval;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TYGD_ASSERT_NEXT(a_accept_gives_result, clock, reset, req_fire, rsp_valid_ff)
   `TYGD_ASSERT_IMPLIES(a_code_matches_flag, clock, reset, rsp_valid_ff,
      rsp_data_ff.report_valid == (rsp_data_ff.gesture_code != GC_NONE))
   `TYGD_ASSERT_IMPLIES(a_yaw_in_turn, clock, reset, 1'b1,
      state_ff.yaw <= FULL_TURN[15:0])
   `TYGD_ASSERT_IMPLIES(a_level_flip_exclusive, clock, reset, 1'b1,
      !(state_ff.latches[LAT_LEVEL] && state_ff.latches[LAT_FLIP]))
   `TYGD_ASSERT_IMPLIES(a_tilt_clear_when_held, clock, reset,
      state_ff.latches[LAT_LEVEL] || state_ff.latches[LAT_FLIP],
      (state_ff.latches & TILT_MASK) == '0)

endmodule
